### rtl/sm4_pkg.sv
package sm4_pkg;

    localparam int SM4_ROUNDS = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    // one word in flight: state words x0..x3 from the top bits down, plus frame mark
    typedef struct packed {
        logic [127:0] x;
        logic         last;
    } stage_t;

    // round key write from the expander into the key store
    typedef struct packed {
        logic        en;
        logic [31:0] key;
    } rk_wr_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // data path transform: s-box then L
    function automatic logic [31:0] t_data(input logic [31:0] v);
        logic [31:0] b;
        b = sub_word(v);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // key schedule transform: s-box then L'
    function automatic logic [31:0] t_key(input logic [31:0] v);
        logic [31:0] b;
        b = sub_word(v);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // ck byte j of round i is (4i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [7:0] i);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = 8'(({i[5:0], 2'b00} + 8'(j)) * 8'd7);
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage

### rtl/sm4_round_cell.sv
module sm4_round_cell
    import sm4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  stage_t      in_data,
    input  logic [31:0] round_key,
    output logic        out_valid,
    input  logic        out_ready,
    output stage_t      out_data
);

    logic        valid_reg;
    stage_t      data_reg;
    stage_t      data_next;
    logic [31:0] mix;

    // slot frees up when empty or when the neighbor takes the word
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        mix            = in_data.x[95:64] ^ in_data.x[63:32] ^ in_data.x[31:0] ^ round_key;
        data_next.x    = {in_data.x[95:0], in_data.x[127:96] ^ t_data(mix)};
        data_next.last = in_data.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/sm4_key_expand.sv
module sm4_key_expand
    import sm4_pkg::*;
#(
    parameter int ROUNDS = SM4_ROUNDS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]               cfg_data,
    output logic                      busy,
    output rk_wr_t                    rk_wr,
    output logic [$clog2(ROUNDS)-1:0] rk_idx
);

    localparam int CNT_W = $clog2(ROUNDS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_IDLE
    } state_t;

    state_t             state_reg;
    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic [31:0]        k_reg [4];
    logic [CNT_W-1:0]   cnt_reg;
    logic [31:0]        nk;

    assign nk = k_reg[0] ^ t_key(k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ ck_word(8'(cnt_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                k_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_index == CFG_KEY_HIGH)
        begin
            key_high_reg <= cfg_data;
            state_reg    <= ST_LOAD;
        end
        else if (cfg_valid && cfg_index == CFG_KEY_LOW)
        begin
            key_low_reg <= cfg_data;
            state_reg   <= ST_LOAD;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    k_reg[0]  <= key_high_reg[63:32] ^ FK0;
                    k_reg[1]  <= key_high_reg[31:0] ^ FK1;
                    k_reg[2]  <= key_low_reg[63:32] ^ FK2;
                    k_reg[3]  <= key_low_reg[31:0] ^ FK3;
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    k_reg[0] <= k_reg[1];
                    k_reg[1] <= k_reg[2];
                    k_reg[2] <= k_reg[3];
                    k_reg[3] <= nk;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ROUNDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rk_wr.en  = (state_reg == ST_RUN);
    assign rk_wr.key = nk;
    assign rk_idx    = cnt_reg;

endmodule

### rtl/sm4_block_encrypt.sv
// channel  | dir | signals                                 | moves
// ---------+-----+-----------------------------------------+---------------------------------
// s_axis   | in  | tvalid tready tdata[127:0] tlast        | one plaintext block per word
// m_axis   | out | tvalid tready tdata[127:0] tlast        | one ciphertext block per word
// cfg      | in  | cfg_valid cfg_ready cfg_index cfg_data  | one key half per word
//
// a row of ROUNDS round cells, one sm4 round each; a word moves one cell per cycle
// unless the cell ahead of it is held, and the last cell drives m_axis; one block
// per cycle while no key expansion, key write or m_axis stall holds the flow
// reset loads the all-zero key and expands it: a load state, then a run state that
// writes one round key per cycle from the shared t' unit; a key write restarts that same expansion
// s_axis_tready stays low while the round keys are expanded or a key write is offered
// a stall on m_axis backs up cell by cell; empty cells still take new blocks
module sm4_block_encrypt
    import sm4_pkg::*;
#(
    parameter int ROUNDS = SM4_ROUNDS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,   // block_high[63:0], block_low[127:64]
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [127:0]         m_axis_tdata,   // cipher_high[63:0], cipher_low[127:64]
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int IDX_W = $clog2(ROUNDS);

    logic             busy;
    rk_wr_t           rk_wr;
    logic [IDX_W-1:0] rk_idx;
    logic [31:0]      rk_reg [ROUNDS];

    logic             valid  [ROUNDS+1];
    logic             ready  [ROUNDS+1];
    stage_t           data   [ROUNDS+1];
    logic             gate;

    // key writes are always taken; they restart the expansion
    assign cfg_ready = 1'b1;

    sm4_key_expand #(
        .ROUNDS (ROUNDS)
    ) u_key_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .rk_wr     (rk_wr),
        .rk_idx    (rk_idx)
    );

    // round key store, entry i feeds cell i
    always_ff @(posedge clk)
    begin
        if (rk_wr.en)
        begin
            rk_reg[rk_idx] <= rk_wr.key;
        end
    end

    // input words x0..x3 big-endian: block_high carries x0 x1, block_low x2 x3
    assign gate          = !busy && !cfg_valid;
    assign s_axis_tready = ready[0] && gate;
    assign valid[0]      = s_axis_tvalid && gate;
    assign data[0].x     = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign data[0].last  = s_axis_tlast;

    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_cell
        sm4_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[g]),
            .in_ready  (ready[g]),
            .in_data   (data[g]),
            .round_key (rk_reg[g]),
            .out_valid (valid[g+1]),
            .out_ready (ready[g+1]),
            .out_data  (data[g+1])
        );
    end

    // the last cell is the output register; words come out reversed
    assign ready[ROUNDS]  = m_axis_tready;
    assign m_axis_tvalid  = valid[ROUNDS];
    assign m_axis_tdata   = {data[ROUNDS].x[95:64], data[ROUNDS].x[127:96],
                             data[ROUNDS].x[31:0],  data[ROUNDS].x[63:32]};
    assign m_axis_tlast   = data[ROUNDS].last;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("block accepted during key expansion");

    a_key_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW)) |=> busy)
        else $error("key write did not start expansion");

    a_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rk_wr.en |-> busy)
        else $error("round key written outside expansion");
`endif

endmodule

### verif/sm4_block_encrypt_tb.sv
module sm4_block_encrypt_tb;
    import sm4_pkg::*;

    localparam int ROUND_COUNT = SM4_ROUNDS;

    // register indexes past the two key halves; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [63:0] ALL_ZERO = 64'h0;
    localparam logic [63:0] ALL_ONE  = 64'hffff_ffff_ffff_ffff;

    // family key mask fk0..fk3, most significant word first
    localparam logic [127:0] FK_MASK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    // s-box, entry 0 in the top byte
    localparam logic [2047:0] SUBST_TAB = {
        128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } block_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [127:0]         m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_HIGH;
    logic [63:0]          cfg_data = '0;

    // testbench copy of the key registers and the expanded schedule
    logic [63:0] key_hi_shadow = '0;
    logic [63:0] key_lo_shadow = '0;
    logic [31:0] round_key [ROUND_COUNT];

    block_t plain_q[$];     // plaintext words not yet offered
    block_t cipher_due[$];  // ciphertext words predicted, oldest first
    block_t cur_plain;      // plaintext word currently on s_axis

    int src_gap = 0;
    int src_calm = 0;
    int snk_gap = 0;
    int snk_calm = 0;
    int mismatches = 0;

    sm4_block_encrypt dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("sm4_block_encrypt test failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] subst32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
        begin
            r[8*i +: 8] = SUBST_TAB[2047 - 8*int'(v[8*i +: 8]) -: 8];
        end
        return r;
    endfunction

    // round function: substitution then the diffusion map with taps 2, 10, 18, 24
    function automatic logic [31:0] mix_data(input logic [31:0] v);
        logic [31:0] b;
        b = subst32(v);
        return b ^ rot32(b, 2) ^ rot32(b, 10) ^ rot32(b, 18) ^ rot32(b, 24);
    endfunction

    // schedule function: substitution then the lighter map with taps 13, 23
    function automatic logic [31:0] mix_sched(input logic [31:0] v);
        logic [31:0] b;
        b = subst32(v);
        return b ^ rot32(b, 13) ^ rot32(b, 23);
    endfunction

    function automatic void expand_round_keys();
        logic [127:0] k;
        logic [31:0]  ck;
        logic [31:0]  nk;
        logic [31:0]  b;
        k = {key_hi_shadow, key_lo_shadow} ^ FK_MASK;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            // ck byte j of round r is (4r + j) * 7 mod 256
            ck = '0;
            for (int j = 0; j < 4; j++)
            begin
                b = (4 * r + j) * 7;
                ck = {ck[23:0], b[7:0]};
            end
            nk = k[127:96] ^ mix_sched(k[95:64] ^ k[63:32] ^ k[31:0] ^ ck);
            round_key[r] = nk;
            k = {k[95:0], nk};
        end
    endfunction

    function automatic block_t encrypt_block(input block_t p);
        logic [127:0] x;
        logic [31:0]  nx;
        block_t       c;
        x = {p.hi, p.lo};
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            nx = x[127:96] ^ mix_data(x[95:64] ^ x[63:32] ^ x[31:0] ^ round_key[r]);
            x = {x[95:0], nx};
        end
        // output order is reversed: x35 x34 x33 x32
        c.hi = {x[31:0], x[63:32]};
        c.lo = {x[95:64], x[127:96]};
        c.last = p.last;
        return c;
    endfunction

    initial
    begin
        expand_round_keys();
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- s_axis driver

    always @(posedge clk or negedge rst_n)
    begin : plain_driver
        logic hold;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            hold = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                // predict at acceptance, key cannot change while words are in flight
                cipher_due.push_back(encrypt_block(cur_plain));
                if (src_calm > 0)
                begin
                    src_calm--;
                    src_gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        src_calm = $urandom_range(10, 60);
                    src_gap = $urandom_range(0, 10);
                end
            end
            if (!hold)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (plain_q.size() > 0)
                begin
                    cur_plain = plain_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_plain.lo, cur_plain.hi};
                    s_axis_tlast  <= cur_plain.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- m_axis monitor

    always @(posedge clk or negedge rst_n)
    begin : cipher_monitor
        block_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_due.size() == 0)
                begin
                    report_mismatch("ciphertext word with none outstanding, cipher_high",
                                    m_axis_tdata[63:0], ALL_ZERO);
                end
                else
                begin
                    want = cipher_due.pop_front();
                    if (m_axis_tdata[63:0] !== want.hi)
                        report_mismatch("cipher_high", m_axis_tdata[63:0], want.hi);
                    if (m_axis_tdata[127:64] !== want.lo)
                        report_mismatch("cipher_low", m_axis_tdata[127:64], want.lo);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_out", 64'(m_axis_tlast), 64'(want.last));
                end
                if (snk_calm > 0)
                begin
                    snk_calm--;
                    snk_gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        snk_calm = $urandom_range(10, 60);
                    snk_gap = $urandom_range(0, 10);
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_HIGH)
        begin
            key_hi_shadow = val;
            expand_round_keys();
        end
        else if (idx == CFG_KEY_LOW)
        begin
            key_lo_shadow = val;
            expand_round_keys();
        end
    endtask

    task automatic add_block(input logic [63:0] hi, input logic [63:0] lo, input logic last);
        block_t b;
        b.hi = hi;
        b.lo = lo;
        b.last = last;
        plain_q.push_back(b);
    endtask

    // wait for the pipe to drain, then let it settle before the next phase
    task automatic drain_pipe();
        do
            @(negedge clk);
        while (plain_q.size() != 0 || s_axis_tvalid || cipher_due.size() != 0);
        repeat (ROUND_COUNT + 8) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_half();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return ALL_ZERO;
        else if (pick == 1)
            return ALL_ONE;
        else
            return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_key_half();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return ALL_ZERO;
        else if (pick == 1)
            return ALL_ONE;
        else
            return {$urandom(), $urandom()};
    endfunction

    initial
    begin : stimulus
        int count;
        int mode;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // all-zero key left by reset
        add_block(ALL_ZERO, ALL_ZERO, 1'b0);
        add_block(ALL_ONE, ALL_ONE, 1'b1);
        add_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
        add_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        add_block(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b0);
        add_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
        drain_pipe();

        // standard known-answer key, expected 681edf34d206965e 86b3e94f536e4246
        write_key(CFG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
        write_key(CFG_KEY_LOW, 64'hfedc_ba98_7654_3210);
        add_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
        add_block(ALL_ZERO, ALL_ZERO, 1'b1);
        add_block(ALL_ONE, ALL_ONE, 1'b0);
        drain_pipe();

        // writes past the last key register leave the key alone
        write_key(CFG_SPARE_2, ALL_ONE);
        write_key(CFG_SPARE_3, {$urandom(), $urandom()});
        add_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
        drain_pipe();

        // all-ones key
        write_key(CFG_KEY_HIGH, ALL_ONE);
        write_key(CFG_KEY_LOW, ALL_ONE);
        add_block(ALL_ZERO, ALL_ZERO, 1'b1);
        add_block(ALL_ONE, ALL_ONE, 1'b0);
        add_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
        drain_pipe();

        // zero key written back explicitly
        write_key(CFG_KEY_HIGH, ALL_ZERO);
        write_key(CFG_KEY_LOW, ALL_ZERO);
        add_block(ALL_ONE, ALL_ZERO, 1'b0);
        add_block(ALL_ZERO, ALL_ONE, 1'b1);
        drain_pipe();

        // random phases, each with its own key setting
        for (int phase = 0; phase < 10; phase++)
        begin
            mode = $urandom_range(0, 5);
            case (mode)
                0:
                begin
                    write_key(CFG_KEY_HIGH, {$urandom(), $urandom()});
                    write_key(CFG_KEY_LOW, {$urandom(), $urandom()});
                end
                1: write_key(CFG_KEY_HIGH, rand_key_half());
                2: write_key(CFG_KEY_LOW, rand_key_half());
                3:
                begin
                    write_key(CFG_KEY_LOW, $urandom_range(0, 1) ? ALL_ONE : ALL_ZERO);
                    write_key(CFG_KEY_HIGH, $urandom_range(0, 1) ? ALL_ONE : ALL_ZERO);
                end
                4:
                begin
                    write_key(CFG_SPARE_2, {$urandom(), $urandom()});
                    write_key(CFG_KEY_LOW, rand_key_half());
                end
                default:
                begin
                    write_key(CFG_KEY_HIGH, rand_key_half());
                    write_key(CFG_SPARE_3, {$urandom(), $urandom()});
                    write_key(CFG_KEY_LOW, rand_key_half());
                end
            endcase
            count = $urandom_range(165, 205);
            for (int i = 0; i < count; i++)
            begin
                // messages of a few blocks each, last flag closes one
                add_block(rand_half(), rand_half(), $urandom_range(0, 3) == 0);
            end
            drain_pipe();
        end

        if (mismatches == 0)
            $display("sm4_block_encrypt test passed");
        else
            $display("sm4_block_encrypt test failed");
        $finish;
    end

endmodule
